>>> src/sfp_pkg.sv
// shared types and codes for the sync framed byte parser
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int ByteW  = 8;
  localparam int CountW = 32;
  localparam int PhaseW = 3;
  localparam int KindW  = 2;
  localparam int CfgIdxW = 2;

  // parser phase codes
  localparam logic [PhaseW-1:0] PH_SYNC_A = 3'd0;
  localparam logic [PhaseW-1:0] PH_SYNC_B = 3'd1;
  localparam logic [PhaseW-1:0] PH_TYPE   = 3'd2;
  localparam logic [PhaseW-1:0] PH_LEN    = 3'd3;
  localparam logic [PhaseW-1:0] PH_DATA   = 3'd4;
  localparam logic [PhaseW-1:0] PH_CK_LO  = 3'd5;
  localparam logic [PhaseW-1:0] PH_CK_HI  = 3'd6;

  // event kinds
  localparam logic [KindW-1:0] EV_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] EV_GOOD    = 2'd1;
  localparam logic [KindW-1:0] EV_BAD     = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SYNC_SECOND = 2'd1;

  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hBC;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'hCF;

  typedef struct packed {
    logic [KindW-1:0]  event_kind;
    logic [ByteW-1:0]  frame_type;
    logic [ByteW-1:0]  frame_length;
    logic [ByteW-1:0]  payload_byte;
    logic [ByteW-1:0]  payload_index;
    logic [CountW-1:0] good_count;
    logic [CountW-1:0] error_count;
  } sfp_result_t;

endpackage

>>> src/sfp_parse.sv
// frame parser state, fletcher-8 sum and frame counters
`timescale 1ns / 1ps

module sfp_parse (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step_en,
  input  logic [sfp_pkg::ByteW-1:0] rx_byte,
  input  logic [sfp_pkg::ByteW-1:0] sync_first,
  input  logic [sfp_pkg::ByteW-1:0] sync_second,
  output logic                      res_valid,
  output sfp_pkg::sfp_result_t      res
);
  import sfp_pkg::*;

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [ByteW-1:0]  type_r, type_nxt;
  logic [ByteW-1:0]  len_r, len_nxt;
  logic [ByteW-1:0]  pos_r, pos_nxt;
  logic [ByteW-1:0]  sum_lo_r, sum_lo_nxt;
  logic [ByteW-1:0]  sum_hi_r, sum_hi_nxt;
  logic [ByteW-1:0]  rcv_lo_r, rcv_lo_nxt;
  logic [CountW-1:0] good_r, good_nxt;
  logic [CountW-1:0] bad_r, bad_nxt;
  logic [ByteW-1:0]  acc_lo;
  logic [ByteW-1:0]  acc_hi;

  assign acc_lo = sum_lo_r + rx_byte;
  assign acc_hi = sum_hi_r + acc_lo;

  always_comb begin
    phase_nxt  = phase_r;
    type_nxt   = type_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    sum_lo_nxt = sum_lo_r;
    sum_hi_nxt = sum_hi_r;
    rcv_lo_nxt = rcv_lo_r;
    good_nxt   = good_r;
    bad_nxt    = bad_r;
    res_valid  = 1'b0;
    res.event_kind    = EV_PAYLOAD;
    res.payload_byte  = '0;
    res.payload_index = '0;
    unique case (phase_r)
      PH_SYNC_B: begin
        // a repeated first sync byte keeps waiting
        if (rx_byte == sync_second) begin
          phase_nxt = PH_TYPE;
        end else if (rx_byte != sync_first) begin
          phase_nxt = PH_SYNC_A;
        end
      end
      PH_TYPE: begin
        type_nxt   = rx_byte;
        sum_lo_nxt = rx_byte;
        sum_hi_nxt = rx_byte;
        phase_nxt  = PH_LEN;
      end
      PH_LEN: begin
        len_nxt    = rx_byte;
        sum_lo_nxt = acc_lo;
        sum_hi_nxt = acc_hi;
        pos_nxt    = '0;
        phase_nxt  = (rx_byte == '0) ? PH_CK_LO : PH_DATA;
      end
      PH_DATA: begin
        sum_lo_nxt = acc_lo;
        sum_hi_nxt = acc_hi;
        pos_nxt    = pos_r + 1'b1;
        if (pos_nxt >= len_r) begin
          phase_nxt = PH_CK_LO;
        end
        res_valid         = 1'b1;
        res.event_kind    = EV_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = pos_r;
      end
      PH_CK_LO: begin
        rcv_lo_nxt = rx_byte;
        phase_nxt  = PH_CK_HI;
      end
      PH_CK_HI: begin
        phase_nxt = PH_SYNC_A;
        res_valid = 1'b1;
        if (rcv_lo_r == sum_lo_r && rx_byte == sum_hi_r) begin
          good_nxt       = good_r + 1'b1;
          res.event_kind = EV_GOOD;
        end else begin
          bad_nxt        = bad_r + 1'b1;
          res.event_kind = EV_BAD;
        end
      end
      default: begin
        // hunting, also covers the unused phase code
        phase_nxt = (rx_byte == sync_first) ? PH_SYNC_B : PH_SYNC_A;
      end
    endcase
    res.frame_type   = type_r;
    res.frame_length = len_r;
    res.good_count   = good_nxt;
    res.error_count  = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC_A;
      type_r   <= '0;
      len_r    <= '0;
      pos_r    <= '0;
      sum_lo_r <= '0;
      sum_hi_r <= '0;
      rcv_lo_r <= '0;
      good_r   <= '0;
      bad_r    <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      sum_lo_r <= sum_lo_nxt;
      sum_hi_r <= sum_hi_nxt;
      rcv_lo_r <= rcv_lo_nxt;
      good_r   <= good_nxt;
      bad_r    <= bad_nxt;
    end
  end

endmodule

>>> src/sync_frame_parser_fletcher8_core.sv
// top level of the sync framed byte parser with fletcher-8 check
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   in_rx_byte
//   out_     output     out_valid / out_stall event kind, frame fields, counters
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// one byte per cycle unless out_stall holds a full output register: a byte waits in
// the input register until its step loads any result into the output register.
// the step stage is one fletcher add pair and a phase decode.
// synchronous active-low reset clears phase, sums and counters and loads the sync
// registers with their default values.
// out_stall holds the output register; in_stall rises only while a byte waits
// behind a full, stalled output register. cfg_ready is always high.
`timescale 1ns / 1ps

module sync_frame_parser_fletcher8_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [sfp_pkg::ByteW-1:0]   in_rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sfp_pkg::KindW-1:0]   out_event_kind,
  output logic [sfp_pkg::ByteW-1:0]   out_frame_type,
  output logic [sfp_pkg::ByteW-1:0]   out_frame_length,
  output logic [sfp_pkg::ByteW-1:0]   out_payload_byte,
  output logic [sfp_pkg::ByteW-1:0]   out_payload_index,
  output logic [sfp_pkg::CountW-1:0]  out_good_count,
  output logic [sfp_pkg::CountW-1:0]  out_error_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sfp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sfp_pkg::ByteW-1:0]   cfg_wdata
);
  import sfp_pkg::*;

  logic              in_vld_r;
  logic [ByteW-1:0]  in_byte_r;
  logic              out_vld_r;
  sfp_result_t       out_r;
  logic [ByteW-1:0]  sync_first_r;
  logic [ByteW-1:0]  sync_second_r;
  logic              step_en;
  logic              in_take;
  logic              res_valid;
  sfp_result_t       res;

  assign cfg_ready = 1'b1;

  // the stage may step whenever the output register can take a new item
  assign step_en  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step_en;
  assign in_take  = in_valid && !in_stall;

  sfp_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .rx_byte     (in_byte_r),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step_en) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_en) begin
      out_vld_r <= res_valid;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_kind    = out_r.event_kind;
  assign out_frame_type    = out_r.frame_type;
  assign out_frame_length  = out_r.frame_length;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_payload_index = out_r.payload_index;
  assign out_good_count    = out_r.good_count;
  assign out_error_count   = out_r.error_count;

endmodule
